/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define AST_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define AST_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define AST_PROP(lbl, clk, rstn, prop, msg)
`define AST_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* sv/mbwr_pkg.sv */
package mbwr_pkg;

    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 4;
    localparam int CNT_W   = 4;

    localparam logic              CMD_START = 1'b0;
    localparam logic              CMD_ADV   = 1'b1;
    localparam logic [CNT_W-1:0]  CNT_FULL  = 4'd8;
    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'hff;

    typedef struct packed {
        logic [BYTE_W-1:0] window;
        logic              byte_taken;
        logic              end_of_stream;
    } result_t;

    // top n bits of a byte set, n saturating at 8
    function automatic logic [BYTE_W-1:0] top_mask(input logic [CNT_W-1:0] n);
        logic [2*BYTE_W-1:0] t;
        t = 16'hff00 >> n;
        if (n > CNT_FULL)
            return PAD_BYTE;
        return t[BYTE_W-1:0];
    endfunction

    function automatic logic stream_over(input logic              seen,
                                         input logic [CNT_W-1:0]  bits,
                                         input logic [BYTE_W-1:0] la,
                                         input logic [BYTE_W-1:0] win);
        logic [BYTE_W-1:0] m;
        m = '0;
        if (!seen)
            return 1'b0;
        if (bits == '0)
            return 1'b1;
        if (bits > CNT_FULL) begin
            m = top_mask(bits - CNT_FULL);
            return ((la & m) == m) && (win == PAD_BYTE);
        end
        m = top_mask(bits);
        return (win & m) == m;
    endfunction

endpackage

/* sv/msb_bit_window_reader_top.sv */
// MSB-first bit window with ones padding, for a Huffman decoder front end.
// Input channel (in_valid / in_stall) carries command, shift_bits, next_byte
// and at_end; output channel (out_valid / out_stall) returns window,
// byte_taken and end_of_stream, one result per input transaction.
// A start command clears the stream state; two advances of 8 then prime
// the window. Each advance shifts out 0..8 bits and pulls next_byte into
// the lookahead when it runs short (byte_taken says so); with at_end high
// ones are padded and a bit counter runs down to the end of stream.
// Each result is registered in the output register, or in the skid entry.
// Throughput: 1 transaction per cycle while in_stall is low; the state update is a single pass
// of shift/mask logic feeding the state and result registers.
// Results sit in an output register backed by one skid entry, so a
// transaction is still taken in the cycle the receiver first stalls;
// in_stall rises only once the skid entry is occupied, and nothing is lost.
// Reset: empty output, window and lookahead 0, lookahead count 8, no end
// seen; the block takes transactions straight after reset.
`include "assert_macros.svh"

module msb_bit_window_reader_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [mbwr_pkg::SHIFT_W-1:0] shift_bits,
    input  logic [mbwr_pkg::BYTE_W-1:0]  next_byte,
    input  logic                         at_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mbwr_pkg::BYTE_W-1:0]  window,
    output logic                         byte_taken,
    output logic                         end_of_stream
);
    import mbwr_pkg::*;

    logic [BYTE_W-1:0] win_reg,   win_next;
    logic [BYTE_W-1:0] la_reg,    la_next;
    logic [CNT_W-1:0]  la_cnt_reg, la_cnt_next;
    logic              seen_reg,  seen_next;
    logic [CNT_W-1:0]  bue_reg,   bue_next;

    result_t res_next, out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept, out_take;

    logic [CNT_W-1:0]    d, cnt;
    logic                load;
    logic [2*BYTE_W-1:0] w_sh, la_sh;
    logic [CNT_W:0]      s, remain;
    logic [BYTE_W-1:0]   loaded;
    logic                taken;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        d      = (shift_bits > CNT_FULL) ? CNT_FULL : shift_bits;
        cnt    = (la_cnt_reg == '0 || la_cnt_reg > CNT_FULL) ? CNT_FULL : la_cnt_reg;
        load   = (d != '0) && (cnt <= d);
        w_sh   = {8'h00, win_reg} << d;
        la_sh  = {8'h00, la_reg} << d;   // upper byte = la >> (8-d)
        s      = {1'b0, CNT_FULL} - {1'b0, d} + {1'b0, cnt};
        loaded = at_end ? PAD_BYTE : next_byte;
        taken  = 1'b0;

        win_next    = w_sh[BYTE_W-1:0] | la_sh[2*BYTE_W-1:BYTE_W];
        la_next     = la_sh[BYTE_W-1:0];
        la_cnt_next = cnt - d;
        seen_next   = seen_reg;
        remain      = {1'b0, bue_reg};
        bue_next    = bue_reg;

        if (load) begin
            if (at_end) begin
                if (!seen_reg) begin
                    seen_next = 1'b1;
                    remain    = {1'b0, CNT_FULL} + {1'b0, cnt};
                end
            end else begin
                taken = 1'b1;
            end
            win_next    = win_next | (loaded >> s);
            la_next     = loaded << (d - cnt);
            la_cnt_next = s[CNT_W-1:0];
        end

        if (seen_next)
            bue_next = ({1'b0, d} > remain) ? '0 : CNT_W'(remain - {1'b0, d});

        if (command == CMD_START) begin
            win_next    = '0;
            la_next     = '0;
            la_cnt_next = CNT_FULL;
            seen_next   = 1'b0;
            bue_next    = '0;
            taken       = 1'b0;
        end

        res_next.window        = win_next;
        res_next.byte_taken    = taken;
        res_next.end_of_stream = stream_over(seen_next, bue_next, la_next, win_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg    <= '0;
            la_reg     <= '0;
            la_cnt_reg <= CNT_FULL;
            seen_reg   <= 1'b0;
            bue_reg    <= '0;
        end else if (accept) begin
            win_reg    <= win_next;
            la_reg     <= la_next;
            la_cnt_reg <= la_cnt_next;
            seen_reg   <= seen_next;
            bue_reg    <= bue_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (out_valid_reg && out_stall)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_take)
                out_reg <= skid_reg;
        end else if (accept) begin
            if (out_valid_reg && out_stall)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window        = out_reg.window;
    assign byte_taken    = out_reg.byte_taken;
    assign end_of_stream = out_reg.end_of_stream;

    `AST_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg,
        "skid entry held while output register empty")
    `AST_PROP(a_accept_lands, clk, rst_n, accept |=> out_valid_reg,
        "accepted transaction has no result queued")
    `AST_NEVER(a_cnt_range, clk, rst_n, (la_cnt_reg == '0) || (la_cnt_reg > CNT_FULL),
        "lookahead count out of 1..8")
    `AST_NEVER(a_bue_range, clk, rst_n, bue_reg > CNT_FULL,
        "bits-until-end counter above 8")

endmodule

/* verif/msb_bit_window_reader_top_tb.sv */
module msb_bit_window_reader_top_tb;
    import mbwr_pkg::*;

    localparam int LIMIT_CYCLES = 250000;
    localparam int RANDOM_ITEMS = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [SHIFT_W-1:0]   shift_bits;
    logic [BYTE_W-1:0]    next_byte;
    logic                 at_end;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    window;
    logic                 byte_taken;
    logic                 end_of_stream;

    // predicted window state
    int win_q;
    int la_q;
    int la_cnt;
    bit end_flag;
    int bits_left;

    result_t expected_windows[$];
    int      errors;
    int      cycles;
    int      items_sent;
    bit      gaps_on;
    bit      stall_on;
    int      hold_left;
    int      stall_left;

    msb_bit_window_reader_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .shift_bits   (shift_bits),
        .next_byte    (next_byte),
        .at_end       (at_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window       (window),
        .byte_taken   (byte_taken),
        .end_of_stream(end_of_stream)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic void clear_window_state();
        win_q     = 0;
        la_q      = 0;
        la_cnt    = CNT_FULL;
        end_flag  = 1'b0;
        bits_left = 0;
    endfunction

    function automatic int top_bits(int n);
        if (n > 8)
            n = 8;
        return (32'hff << (8 - n)) & 32'hff;
    endfunction

    function automatic result_t advance_window(logic cmd, logic [SHIFT_W-1:0] sh,
                                               logic [BYTE_W-1:0] nb, logic fin);
        result_t r;
        int      d;
        int      cnt;
        int      remain;
        int      loaded;
        int      m;
        r = '0;
        if (cmd == CMD_START) begin
            clear_window_state();
        end
        else begin
            d      = (sh > 8) ? 8 : int'(sh);
            cnt    = (la_cnt < 1 || la_cnt > 8) ? 8 : la_cnt;
            remain = bits_left;
            win_q  = (win_q << d) & 32'hff;
            if (d != 0 && cnt <= d) begin
                if (fin) begin
                    if (!end_flag) begin
                        end_flag = 1'b1;
                        remain   = 8 + cnt;
                    end
                    loaded = PAD_BYTE;
                end
                else begin
                    loaded       = nb;
                    r.byte_taken = 1'b1;
                end
                win_q  = win_q | (la_q >> (8 - d));
                win_q  = (win_q | (loaded >> (8 - d + cnt))) & 32'hff;
                la_q   = (loaded << (d - cnt)) & 32'hff;
                la_cnt = 8 - (d - cnt);
            end
            else begin
                win_q  = win_q | (la_q >> (8 - d));
                la_q   = (la_q << d) & 32'hff;
                la_cnt = cnt - d;
            end
            if (end_flag) begin
                remain    = (d > remain) ? 0 : remain - d;
                bits_left = remain & 32'hf;
            end
        end
        r.window = win_q[BYTE_W-1:0];
        if (!end_flag)
            r.end_of_stream = 1'b0;
        else if (bits_left == 0)
            r.end_of_stream = 1'b1;
        else if (bits_left > 8) begin
            m = top_bits(bits_left - 8);
            r.end_of_stream = ((la_q & m) == m) && (win_q == 32'hff);
        end
        else begin
            m = top_bits(bits_left);
            r.end_of_stream = ((win_q & m) == m);
        end
        return r;
    endfunction

    // mostly no idle, some short stretches, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_item(logic cmd, logic [SHIFT_W-1:0] sh, logic [BYTE_W-1:0] nb,
                             logic fin);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        shift_bits <= sh;
        next_byte  <= nb;
        at_end     <= fin;
        do
            @(posedge clk);
        while (in_stall);
        expected_windows.push_back(advance_window(cmd, sh, nb, fin));
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        int n;
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (stall_on) begin
            n = pick_gap();
            out_stall  <= (n > 0);
            stall_left = (n > 0) ? n - 1 : 0;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_windows.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: window=%h byte_taken=%b end_of_stream=%b",
                             window, byte_taken, end_of_stream);
            end
            else begin
                want = expected_windows.pop_front();
                if (window !== want.window || byte_taken !== want.byte_taken
                    || end_of_stream !== want.end_of_stream) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: window exp %h got %h, byte_taken exp %b got %b, %s",
                                 want.window, window, want.byte_taken, byte_taken,
                                 $sformatf("end_of_stream exp %b got %b",
                                           want.end_of_stream, end_of_stream));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("msb_bit_window_reader_top_tb failed");
            $finish;
        end
    end

    task automatic test_directed();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        // advance straight out of reset, before any start
        send_item(CMD_ADV, 4'd4, 8'h5a, 1'b0);
        send_item(CMD_START, 4'd0, 8'h00, 1'b0);
        send_item(CMD_ADV, 4'd8, 8'ha5, 1'b0);
        send_item(CMD_ADV, 4'd8, 8'h3c, 1'b0);
        send_item(CMD_ADV, 4'd1, 8'hff, 1'b0);
        send_item(CMD_ADV, 4'd3, 8'h00, 1'b0);
        send_item(CMD_ADV, 4'd8, 8'h81, 1'b0);
        send_item(CMD_ADV, 4'd5, 8'h7e, 1'b0);
        // zero shift, then saturating shifts
        send_item(CMD_ADV, 4'd0, 8'h12, 1'b0);
        send_item(CMD_ADV, 4'd9, 8'h34, 1'b0);
        send_item(CMD_ADV, 4'd15, 8'h56, 1'b0);
        send_item(CMD_ADV, 4'd2, 8'hff, 1'b0);
        send_item(CMD_ADV, 4'd4, 8'h00, 1'b0);
        // input ends, resumes briefly, then the counter runs out
        send_item(CMD_ADV, 4'd3, 8'h99, 1'b1);
        send_item(CMD_ADV, 4'd2, 8'h99, 1'b1);
        send_item(CMD_ADV, 4'd1, 8'hc3, 1'b0);
        send_item(CMD_ADV, 4'd6, 8'h00, 1'b1);
        send_item(CMD_ADV, 4'd8, 8'h00, 1'b1);
        send_item(CMD_ADV, 4'd8, 8'h00, 1'b1);
        // start with all other fields high, then pad before priming
        send_item(CMD_START, 4'd15, 8'hff, 1'b1);
        send_item(CMD_ADV, 4'd7, 8'h00, 1'b1);
        send_item(CMD_ADV, 4'd8, 8'h00, 1'b1);
        // all-ones stream, then the input ends on a shift that loads no byte
        send_item(CMD_START, 4'd0, 8'h00, 1'b0);
        send_item(CMD_ADV, 4'd8, 8'hff, 1'b0);
        send_item(CMD_ADV, 4'd8, 8'hff, 1'b0);
        send_item(CMD_ADV, 4'd4, 8'h00, 1'b1);
        drain_results();
    endtask

    task automatic send_stream(int len);
        int               end_at;
        logic             fin;
        logic [SHIFT_W-1:0] sh;
        int               r;
        int               i;
        end_at = $urandom_range(2, len);
        send_item(CMD_START, SHIFT_W'($urandom), BYTE_W'($urandom), 1'($urandom));
        send_item(CMD_ADV, 4'd8, BYTE_W'($urandom), 1'b0);
        send_item(CMD_ADV, 4'd8, BYTE_W'($urandom), 1'b0);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                sh = SHIFT_W'($urandom_range(1, 8));
            else if (r < 90)
                sh = '0;
            else
                sh = SHIFT_W'($urandom_range(9, 15));
            if (i >= end_at)
                fin = ($urandom_range(0, 9) != 0);
            else
                fin = ($urandom_range(0, 29) == 0);
            // occasional stray restart mid-stream
            if ($urandom_range(0, 49) == 0)
                send_item(CMD_START, sh, BYTE_W'($urandom), fin);
            else
                send_item(CMD_ADV, sh, BYTE_W'($urandom), fin);
        end
    endtask

    task automatic test_random_streams();
        int start_count;
        int r;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            gaps_on  = (r < 70) || (r >= 85 && r < 92);
            stall_on = (r < 70) || (r >= 92);
            send_stream($urandom_range(4, 40));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        int i;
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        @(posedge clk);
        hold_left = 60;
        send_item(CMD_START, 4'd0, 8'h00, 1'b0);
        for (i = 0; i < 24; i++)
            send_item(CMD_ADV, SHIFT_W'($urandom_range(1, 8)), BYTE_W'($urandom),
                      (i > 18));
        drain_results();
    endtask

    task automatic test_sender_pause();
        int i;
        int burst;
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        for (burst = 0; burst < 3; burst++) begin
            send_item(CMD_START, 4'd0, 8'h00, 1'b0);
            for (i = 0; i < 8; i++)
                send_item(CMD_ADV, SHIFT_W'($urandom_range(1, 8)), BYTE_W'($urandom),
                          (i > 5));
            drain_results();
        end
        stall_on = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_START;
        shift_bits = '0;
        next_byte  = '0;
        at_end     = 1'b0;
        out_stall  = 1'b0;
        errors     = 0;
        cycles     = 0;
        items_sent = 0;
        gaps_on    = 1'b0;
        stall_on   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        clear_window_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_streams();
        test_sender_pause();

        repeat (5) @(posedge clk);
        if (errors == 0 && expected_windows.size() == 0)
            $display("msb_bit_window_reader_top_tb passed");
        else
            $display("msb_bit_window_reader_top_tb failed");
        $finish;
    end

endmodule
